@@ src/mphe_pkg.sv @@
// Shared types and constants of the MessagePack header encoder.
package mphe_pkg;

  // Request kinds
  localparam logic [2:0] MODE_ARRAY = 3'd0;
  localparam logic [2:0] MODE_UINT  = 3'd1;
  localparam logic [2:0] MODE_SINT  = 3'd2;
  localparam logic [2:0] MODE_STR   = 3'd3;
  localparam logic [2:0] MODE_CHAR  = 3'd4;
  localparam logic [2:0] MODE_BOOL  = 3'd5;

  // Format bytes
  localparam logic [7:0] FMT_FIXARRAY = 8'h90;
  localparam logic [7:0] FMT_ARRAY16  = 8'hdc;
  localparam logic [7:0] FMT_ARRAY32  = 8'hdd;
  localparam logic [7:0] FMT_UINT8    = 8'hcc;
  localparam logic [7:0] FMT_UINT16   = 8'hcd;
  localparam logic [7:0] FMT_UINT32   = 8'hce;
  localparam logic [7:0] FMT_UINT64   = 8'hcf;
  localparam logic [7:0] FMT_NEGFIX   = 8'he0;
  localparam logic [7:0] FMT_INT8     = 8'hd0;
  localparam logic [7:0] FMT_INT16    = 8'hd1;
  localparam logic [7:0] FMT_INT32    = 8'hd2;
  localparam logic [7:0] FMT_INT64    = 8'hd3;
  localparam logic [7:0] FMT_FIXSTR   = 8'ha0;
  localparam logic [7:0] FMT_STR8     = 8'hd9;
  localparam logic [7:0] FMT_STR16    = 8'hda;
  localparam logic [7:0] FMT_STR32    = 8'hdb;
  localparam logic [7:0] FMT_FALSE    = 8'hc2;
  localparam logic [7:0] FMT_TRUE     = 8'hc3;

  // Widths
  localparam int unsigned ValueW   = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned WordW    = MaxBytes * ByteW;

  typedef logic [CntW-1:0] cnt_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cnt_t nbytes;
  } dp_status_t;

endpackage

@@ src/mphe_if.sv @@
// Request and byte stream channel interfaces of the MessagePack header encoder.
interface mphe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] value;
  logic [7:0]  char_byte;

  modport source (output valid, output mode, output value, output char_byte, input ready);
  modport sink (input valid, input mode, input value, input char_byte, output ready);
endinterface

interface mphe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

@@ src/mphe_dp.sv @@
// Datapath: size class selection and the byte shift register.
module mphe_dp import mphe_pkg::*; (
  input  logic                 clk_i,
  input  logic [2:0]           mode_i,
  input  logic [ValueW-1:0]    value_i,
  input  logic [ByteW-1:0]     char_byte_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output logic [ByteW-1:0]     out_byte_o
);

  logic [ByteW-1:0]  hdr;
  logic [3:0]        npay;
  logic              valid_mode;
  logic [ValueW-1:0] pay;
  logic [WordW-1:0]  sr_d, sr_q;

  // Pick the format byte and payload size of the request
  always_comb begin
    hdr        = '0;
    npay       = 4'd0;
    valid_mode = 1'b1;
    case (mode_i)
      MODE_ARRAY: begin
        if (value_i[31:4] == '0) begin
          hdr = FMT_FIXARRAY | {4'b0, value_i[3:0]};
        end else if (value_i[31:16] == '0) begin
          hdr = FMT_ARRAY16; npay = 4'd2;
        end else begin
          hdr = FMT_ARRAY32; npay = 4'd4;
        end
      end
      MODE_UINT, MODE_SINT: begin
        if (mode_i == MODE_SINT && value_i[63]) begin
          if (&value_i[63:5]) begin
            hdr = FMT_NEGFIX | {3'b0, value_i[4:0]};
          end else if (&value_i[63:7]) begin
            hdr = FMT_INT8; npay = 4'd1;
          end else if (&value_i[63:15]) begin
            hdr = FMT_INT16; npay = 4'd2;
          end else if (&value_i[63:31]) begin
            hdr = FMT_INT32; npay = 4'd4;
          end else begin
            hdr = FMT_INT64; npay = 4'd8;
          end
        end else begin
          if (value_i[63:7] == '0) begin
            hdr = value_i[7:0];
          end else if (value_i[63:8] == '0) begin
            hdr = FMT_UINT8; npay = 4'd1;
          end else if (value_i[63:16] == '0) begin
            hdr = FMT_UINT16; npay = 4'd2;
          end else if (value_i[63:32] == '0) begin
            hdr = FMT_UINT32; npay = 4'd4;
          end else begin
            hdr = FMT_UINT64; npay = 4'd8;
          end
        end
      end
      MODE_STR: begin
        if (value_i[31:5] == '0) begin
          hdr = FMT_FIXSTR | {3'b0, value_i[4:0]};
        end else if (value_i[31:8] == '0) begin
          hdr = FMT_STR8; npay = 4'd1;
        end else if (value_i[31:16] == '0) begin
          hdr = FMT_STR16; npay = 4'd2;
        end else begin
          hdr = FMT_STR32; npay = 4'd4;
        end
      end
      MODE_CHAR: hdr = char_byte_i;
      MODE_BOOL: hdr = value_i[0] ? FMT_TRUE : FMT_FALSE;
      default:   valid_mode = 1'b0;
    endcase
  end

  // Align payload bytes to the top of the word, most significant first
  always_comb begin
    case (npay)
      4'd1:    pay = {value_i[7:0], 56'b0};
      4'd2:    pay = {value_i[15:0], 48'b0};
      4'd4:    pay = {value_i[31:0], 32'b0};
      4'd8:    pay = value_i;
      default: pay = '0;
    endcase
  end

  assign status_o.nbytes = valid_mode ? CntW'(npay) + cnt_t'(1) : '0;

  // Load or advance the byte shift register
  always_comb begin
    sr_d = sr_q;
    if (cmd_i.load) begin
      sr_d = {hdr, pay};
    end else if (cmd_i.shift) begin
      sr_d = {sr_q[WordW-ByteW-1:0], {ByteW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign out_byte_o = sr_q[WordW-1 -: ByteW];

endmodule

@@ src/mphe_ctrl.sv @@
// Controller: request acceptance and byte emission sequencing.
module mphe_ctrl import mphe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       last_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  cnt_t   cnt_q;
  logic   in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign last_o      = (cnt_q == cnt_t'(1));

  assign cmd_o.load  = in_fire;
  assign cmd_o.shift = out_fire;

  // Hold state and the count of bytes left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire && status_i.nbytes != '0) begin
            cnt_q   <= status_i.nbytes;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            cnt_q <= cnt_q - cnt_t'(1);
            if (last_o) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/msgpack_header_encoder_core.sv @@
// Top level of the MessagePack header encoder.
//
//   channel   dir  fields                       meaning
//   in_req    in   mode, value, char_byte       one element request
//   out_rsp   out  out_byte, last               one encoded byte
//
// A request is taken when the block is idle; it then emits its 1 to 9 bytes
// from a registered shift register, one per cycle while out_rsp is ready,
// and takes no new request until its last byte is taken. Modes 6 and 7
// emit nothing. A stall on out_rsp holds the current byte. Reset clears the
// controller; no clearing pass is needed.
module msgpack_header_encoder_core import mphe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mphe_in_if.sink  in_req,
  mphe_out_if.source out_rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mphe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_ready_o  (in_req.ready),
    .out_valid_o (out_rsp.valid),
    .out_ready_i (out_rsp.ready),
    .last_o      (out_rsp.last),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mphe_dp u_dp (
    .clk_i       (clk_i),
    .mode_i      (in_req.mode),
    .value_i     (in_req.value),
    .char_byte_i (in_req.char_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_byte_o  (out_rsp.out_byte)
  );

endmodule
